[sv/assert_macros.svh]
// Assertion helpers used by heightmap_shade_engine_core.
// They expect the clock clk and the active-low reset rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[sv/hse_pkg.sv]
`timescale 1ns / 1ps
package hse_pkg;

    localparam int MAP_SIDE_DEF = 256;

    localparam int COORD_W  = 8;
    localparam int HEIGHT_W = 16;
    localparam int LIGHT_W  = 10;
    localparam int SHADE_W  = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = 3'd4;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [COORD_W-1:0] MAX_X_RST   = 8'd255;
    localparam logic [COORD_W-1:0] MAX_Y_RST   = 8'd255;
    localparam logic [LIGHT_W-1:0] LIGHT_X_RST = 10'd0;
    localparam logic [LIGHT_W-1:0] LIGHT_Y_RST = 10'd142;
    localparam logic [LIGHT_W-1:0] LIGHT_Z_RST = 10'd213;

    // Central differences need one bit more than a height.
    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NUM_W  = 28;
    localparam int MAG_W  = NUM_W - 1;
    localparam int RAD_W  = PROD_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(MAG_W);

    // The z component is weighted by 64 and the flat term is 64 squared.
    localparam int Z_WEIGHT_LOG2 = 6;
    localparam int FLAT_TERM     = 4096;

    localparam int SHADE_SHIFT = 4;
    localparam int SHADE_OFS   = 16;
    localparam int LIG_MIN     = 2;
    localparam int LIG_MAX     = 31;
    localparam int SHADE_TOP   = 32;
    localparam int LIG_W       = 6;

    typedef struct packed {
        logic               start;
        logic [RAD_W-1:0]   radicand;
        logic [MAG_W-1:0]   dividend;
    } rd_req_t;

    typedef struct packed {
        logic               done;
        logic [MAG_W-1:0]   quot;
    } rd_rsp_t;

endpackage

[sv/hse_root_div.sv]
`timescale 1ns / 1ps
module hse_root_div
(
    input  logic             clk,
    input  logic             rst_n,
    input  hse_pkg::rd_req_t req,
    output hse_pkg::rd_rsp_t rsp
);

    localparam int RAD_W  = hse_pkg::RAD_W;
    localparam int ROOT_W = hse_pkg::ROOT_W;
    localparam int REM_W  = hse_pkg::REM_W;
    localparam int MAG_W  = hse_pkg::MAG_W;
    localparam int CNT_W  = hse_pkg::CNT_W;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ROOT = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]        phase_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [MAG_W-1:0]  dvd_reg;
    logic [ROOT_W-1:0] drem_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              root_bit;
    logic [ROOT_W:0]   drem_sh;
    logic              quot_bit;
    logic [ROOT_W:0]   drem_diff;

    // One result bit per cycle: two radicand bits per root step, one dividend bit per divide step.
    assign rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign root_bit  = (rem_sh >= trial);
    assign drem_sh   = {drem_reg, dvd_reg[MAG_W-1]};
    assign quot_bit  = (drem_sh >= {1'b0, root_reg});
    assign drem_diff = drem_sh - {1'b0, root_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (req.start)
                    begin
                        phase_reg <= PH_ROOT;
                        cnt_reg   <= CNT_W'(ROOT_W - 1);
                    end
                end
                PH_ROOT:
                begin
                    if (cnt_reg == '0)
                    begin
                        phase_reg <= PH_DIV;
                        cnt_reg   <= CNT_W'(MAG_W - 1);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                PH_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            dvd_reg  <= req.dividend;
            drem_reg <= '0;
        end
        else if (phase_reg == PH_ROOT)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= root_bit ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], root_bit};
        end
        else if (phase_reg == PH_DIV)
        begin
            drem_reg <= quot_bit ? drem_diff[ROOT_W-1:0] : drem_sh[ROOT_W-1:0];
            dvd_reg  <= {dvd_reg[MAG_W-2:0], quot_bit};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;

endmodule

[sv/heightmap_shade_engine_core.sv]
// Channel  Handshake            Payload
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
// req      req_valid/req_stall  cmd, col, row, height_delta
// rsp      rsp_valid/rsp_stall  shade
// After reset the height store is cleared one cell per cycle, all of its cells (MAP_SIDE
// rounded up to a power of two, then squared: 65536 at the default), while req_stall stays high.
// An add reads the cell and then writes the sum back; an add to a cell outside the map limits is dropped.
// A query reads four cells of the single-port store, makes four passes through one shared
// multiplier, then runs a bit-serial square root and a bit-serial divide. One transaction
// is in work at a time; a finished shade waits in the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module heightmap_shade_engine_core
#(
    parameter int MAP_SIDE = hse_pkg::MAP_SIDE_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hse_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                cmd,
    input  logic [hse_pkg::COORD_W-1:0]         col,
    input  logic [hse_pkg::COORD_W-1:0]         row,
    input  logic signed [hse_pkg::HEIGHT_W-1:0] height_delta,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [hse_pkg::SHADE_W-1:0]         shade
);

    localparam int COORD_W  = hse_pkg::COORD_W;
    localparam int HEIGHT_W = hse_pkg::HEIGHT_W;
    localparam int LIGHT_W  = hse_pkg::LIGHT_W;
    localparam int DIFF_W   = hse_pkg::DIFF_W;
    localparam int PROD_W   = hse_pkg::PROD_W;
    localparam int NUM_W    = hse_pkg::NUM_W;
    localparam int MAG_W    = hse_pkg::MAG_W;
    localparam int RAD_W    = hse_pkg::RAD_W;
    localparam int LIG_W    = hse_pkg::LIG_W;
    localparam int SHADE_W  = hse_pkg::SHADE_W;

    localparam int CW     = $clog2(MAP_SIDE);
    localparam int XW     = ((CW > COORD_W) ? CW : COORD_W) + 1;
    localparam int ADDR_W = 2 * CW;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [XW-1:0] SIDE_LIM = XW'(MAP_SIDE - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ADD_RD = 3'd2;
    localparam logic [2:0] ST_ADD_WR = 3'd3;
    localparam logic [2:0] ST_RD     = 3'd4;
    localparam logic [2:0] ST_MUL    = 3'd5;
    localparam logic [2:0] ST_SERIAL = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    localparam logic [2:0] LAST_STEP = 3'd4;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [2:0]                 ph_reg;
    logic [ADDR_W-1:0]          clr_reg;

    logic [COORD_W-1:0]         max_x_reg;
    logic [COORD_W-1:0]         max_y_reg;
    logic [LIGHT_W-1:0]         light_x_reg;
    logic [LIGHT_W-1:0]         light_y_reg;
    logic [LIGHT_W-1:0]         light_z_reg;

    logic [COORD_W-1:0]         x_reg;
    logic [COORD_W-1:0]         y_reg;
    logic [HEIGHT_W-1:0]        delta_reg;
    logic [HEIGHT_W-1:0]        a_reg;
    logic signed [DIFF_W-1:0]   dx_reg;
    logic signed [DIFF_W-1:0]   dy_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [RAD_W-1:0]           sq_reg;

    logic                       rsp_valid_reg;
    logic [SHADE_W-1:0]         shade_reg;

    logic [HEIGHT_W-1:0]        height_mem [DEPTH];
    logic [HEIGHT_W-1:0]        mem_rdata_reg;
    logic [ADDR_W-1:0]          mem_addr;
    logic                       mem_we;
    logic [HEIGHT_W-1:0]        mem_wdata;

    logic                       req_accept;
    logic                       add_in_range;
    logic                       out_load;
    logic [XW-1:0]              lim_x;
    logic [XW-1:0]              lim_y;
    logic [XW-1:0]              xe;
    logic [XW-1:0]              ye;
    logic [XW-1:0]              cx;
    logic [XW-1:0]              cy;
    logic [XW-1:0]              xp;
    logic [XW-1:0]              xm;
    logic [XW-1:0]              yp;
    logic [XW-1:0]              ym;
    logic [XW-1:0]              rx;
    logic [XW-1:0]              ry;
    logic [DIFF_W-1:0]          diff;

    logic signed [DIFF_W-1:0]   mul_a;
    logic signed [DIFF_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic [NUM_W-1:0]           mag_full;

    hse_pkg::rd_req_t           rd_req;
    hse_pkg::rd_rsp_t           rd_rsp;

    logic [MAG_W-1:0]           qs;
    logic [MAG_W:0]             qt;
    logic [LIG_W-1:0]           lig;
    logic [LIG_W-1:0]           shade_full;

    function automatic logic [XW-1:0] clamp_hi(input logic [XW-1:0] v, input logic [XW-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    assign cfg_ready  = 1'b1;
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;

    assign lim_x = (XW'(max_x_reg) > SIDE_LIM) ? SIDE_LIM : XW'(max_x_reg);
    assign lim_y = (XW'(max_y_reg) > SIDE_LIM) ? SIDE_LIM : XW'(max_y_reg);

    assign add_in_range = (XW'(col) <= lim_x) && (XW'(row) <= lim_y);

    assign xe = XW'(x_reg);
    assign ye = XW'(y_reg);
    assign cx = clamp_hi(xe, lim_x);
    assign cy = clamp_hi(ye, lim_y);
    assign xp = clamp_hi(xe + XW'(1), lim_x);
    assign yp = clamp_hi(ye + XW'(1), lim_y);
    assign xm = clamp_hi((x_reg == '0) ? '0 : xe - XW'(1), lim_x);
    assign ym = clamp_hi((y_reg == '0) ? '0 : ye - XW'(1), lim_y);

    always_comb
    begin
        case (ph_reg)
            3'd0:
            begin
                rx = xp;
                ry = cy;
            end
            3'd1:
            begin
                rx = xm;
                ry = cy;
            end
            3'd2:
            begin
                rx = cx;
                ry = yp;
            end
            3'd3:
            begin
                rx = cx;
                ry = ym;
            end
            default:
            begin
                rx = cx;
                ry = cy;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_CLEAR:
            begin
                mem_addr = clr_reg;
            end
            ST_RD:
            begin
                mem_addr = {ry[CW-1:0], rx[CW-1:0]};
            end
            default:
            begin
                mem_addr = {ye[CW-1:0], xe[CW-1:0]};
            end
        endcase
    end

    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_ADD_WR);
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : (mem_rdata_reg + delta_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            height_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= height_mem[mem_addr];
    end

    assign diff = {a_reg[HEIGHT_W-1], a_reg} - {mem_rdata_reg[HEIGHT_W-1], mem_rdata_reg};

    always_comb
    begin
        case (ph_reg)
            3'd0:
            begin
                mul_a = dx_reg;
                mul_b = DIFF_W'($signed(light_x_reg));
            end
            3'd1:
            begin
                mul_a = dy_reg;
                mul_b = DIFF_W'($signed(light_y_reg));
            end
            3'd2:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            default:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign mag_full        = num_reg[NUM_W-1] ? (NUM_W'(0) - num_reg) : num_reg;
    assign rd_req.start    = (state_reg == ST_MUL) && (ph_reg == LAST_STEP);
    assign rd_req.radicand = sq_reg;
    assign rd_req.dividend = mag_full[MAG_W-1:0];

    hse_root_div u_root_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rd_req),
        .rsp   (rd_rsp)
    );

    // Negative quotients round away from zero before the shift, as the arithmetic shift does.
    assign qs = rd_rsp.quot >> hse_pkg::SHADE_SHIFT;
    assign qt = ((MAG_W + 1)'(rd_rsp.quot) + (MAG_W + 1)'((1 << hse_pkg::SHADE_SHIFT) - 1))
                >> hse_pkg::SHADE_SHIFT;

    always_comb
    begin
        if (num_reg[NUM_W-1])
        begin
            if (qt >= (MAG_W + 1)'(hse_pkg::SHADE_OFS - hse_pkg::LIG_MIN))
            begin
                lig = LIG_W'(hse_pkg::LIG_MIN);
            end
            else
            begin
                lig = LIG_W'(hse_pkg::SHADE_OFS) - LIG_W'(qt[SHADE_W-1:0]);
            end
        end
        else
        begin
            if (qs >= MAG_W'(hse_pkg::LIG_MAX - hse_pkg::SHADE_OFS))
            begin
                lig = LIG_W'(hse_pkg::LIG_MAX);
            end
            else
            begin
                lig = LIG_W'(hse_pkg::SHADE_OFS) + LIG_W'(qs[SHADE_W-1:0]);
            end
        end
    end

    assign shade_full = LIG_W'(hse_pkg::SHADE_TOP) - lig;
    assign out_load   = (state_reg == ST_OUT) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (cmd == hse_pkg::CMD_QUERY)
                    begin
                        state_next = ST_RD;
                    end
                    else if (add_in_range)
                    begin
                        state_next = ST_ADD_RD;
                    end
                end
            end
            ST_ADD_RD:
            begin
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_RD:
            begin
                if (ph_reg == LAST_STEP)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (ph_reg == LAST_STEP)
                begin
                    state_next = ST_SERIAL;
                end
            end
            ST_SERIAL:
            begin
                if (rd_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ph_reg        <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_next != state_reg)
            begin
                ph_reg <= '0;
            end
            else if (state_reg == ST_RD || state_reg == ST_MUL)
            begin
                ph_reg <= ph_reg + 1'b1;
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg   <= hse_pkg::MAX_X_RST;
            max_y_reg   <= hse_pkg::MAX_Y_RST;
            light_x_reg <= hse_pkg::LIGHT_X_RST;
            light_y_reg <= hse_pkg::LIGHT_Y_RST;
            light_z_reg <= hse_pkg::LIGHT_Z_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hse_pkg::REG_MAX_X:   max_x_reg   <= cfg_data[COORD_W-1:0];
                hse_pkg::REG_MAX_Y:   max_y_reg   <= cfg_data[COORD_W-1:0];
                hse_pkg::REG_LIGHT_X: light_x_reg <= cfg_data[LIGHT_W-1:0];
                hse_pkg::REG_LIGHT_Y: light_y_reg <= cfg_data[LIGHT_W-1:0];
                hse_pkg::REG_LIGHT_Z: light_z_reg <= cfg_data[LIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            x_reg     <= col;
            y_reg     <= row;
            delta_reg <= height_delta;
            num_reg   <= NUM_W'($signed(light_z_reg)) << hse_pkg::Z_WEIGHT_LOG2;
            sq_reg    <= RAD_W'(hse_pkg::FLAT_TERM);
        end
        if (state_reg == ST_RD)
        begin
            case (ph_reg)
                3'd1: a_reg  <= mem_rdata_reg;
                3'd2: dy_reg <= diff;
                3'd3: a_reg  <= mem_rdata_reg;
                3'd4: dx_reg <= diff;
                default:
                begin
                end
            endcase
        end
        if (state_reg == ST_MUL)
        begin
            case (ph_reg)
                3'd0: num_reg <= num_reg + prod[NUM_W-1:0];
                3'd1: num_reg <= num_reg + prod[NUM_W-1:0];
                3'd2: sq_reg  <= sq_reg + prod[RAD_W-1:0];
                3'd3: sq_reg  <= sq_reg + prod[RAD_W-1:0];
                default:
                begin
                end
            endcase
        end
        if (out_load)
        begin
            shade_reg <= shade_full[SHADE_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign shade     = shade_reg;

    `ASSERT_IMP(a_clear_blocks_req, state_reg == ST_CLEAR, req_stall)
    `ASSERT_IMP(a_store_write_src, mem_we, state_reg == ST_CLEAR || state_reg == ST_ADD_WR)
    `ASSERT_IMP(a_shade_range, rsp_valid, shade != '0 && shade != '1)
    `ASSERT_NXT(a_rsp_from_out, state_reg != ST_OUT && !rsp_valid, !rsp_valid)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import hse_pkg::*;

    localparam int QUIET_LIMIT  = 300000;
    localparam int SETTLE_HOLD  = 80;
    localparam int PHASE_ITEMS  = 225;
    localparam int PHASE_COUNT  = 8;

    class shade_scoreboard;
        bit signed [HEIGHT_W-1:0] heights [MAP_SIDE_DEF * MAP_SIDE_DEF];
        bit [COORD_W-1:0]         max_col;
        bit [COORD_W-1:0]         max_row;
        bit signed [LIGHT_W-1:0]  lx;
        bit signed [LIGHT_W-1:0]  ly;
        bit signed [LIGHT_W-1:0]  lz;
        bit [SHADE_W-1:0]         expected_shades [$];
        int                       mismatches;
        int                       shades_checked;
        int                       queries_seen;
        int                       adds_applied;
        int                       adds_ignored;

        function new();
            max_col = MAX_X_RST;
            max_row = MAX_Y_RST;
            lx      = LIGHT_X_RST;
            ly      = LIGHT_Y_RST;
            lz      = LIGHT_Z_RST;
        endfunction

        function void apply_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MAX_X:   max_col = data[COORD_W-1:0];
                REG_MAX_Y:   max_row = data[COORD_W-1:0];
                REG_LIGHT_X: lx = data[LIGHT_W-1:0];
                REG_LIGHT_Y: ly = data[LIGHT_W-1:0];
                REG_LIGHT_Z: lz = data[LIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        function int limit_of(bit [COORD_W-1:0] m);
            return (int'(m) > MAP_SIDE_DEF - 1) ? MAP_SIDE_DEF - 1 : int'(m);
        endfunction

        function int height_at(int x, int y);
            int cx;
            int cy;
            cx = (x < 0) ? 0 : ((x > limit_of(max_col)) ? limit_of(max_col) : x);
            cy = (y < 0) ? 0 : ((y > limit_of(max_row)) ? limit_of(max_row) : y);
            return int'(heights[cy * MAP_SIDE_DEF + cx]);
        endfunction

        function longint floor_sqrt(longint v);
            longint root;
            longint trial;
            root = 0;
            for (int b = 20; b >= 0; b--)
            begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        function bit [SHADE_W-1:0] predict_shade(int c, int r);
            longint d_col;
            longint d_row;
            longint num;
            longint den;
            longint quot;
            longint lig;
            bit [SHADE_W-1:0] level;
            d_col = height_at(c + 1, r) - height_at(c - 1, r);
            d_row = height_at(c, r + 1) - height_at(c, r - 1);
            num = d_row * longint'(lx) + d_col * longint'(ly)
                + (longint'(lz) <<< Z_WEIGHT_LOG2);
            den = floor_sqrt(d_row * d_row + d_col * d_col + FLAT_TERM);
            quot = num / den;
            lig = SHADE_OFS + (quot >>> SHADE_SHIFT);
            if (lig < LIG_MIN)
                lig = LIG_MIN;
            if (lig > LIG_MAX)
                lig = LIG_MAX;
            level = SHADE_W'(SHADE_TOP - lig);
            return level;
        endfunction

        function void note_request(bit c, bit [COORD_W-1:0] x, bit [COORD_W-1:0] y,
                                   bit signed [HEIGHT_W-1:0] d);
            if (c == CMD_QUERY)
            begin
                expected_shades.push_back(predict_shade(int'(x), int'(y)));
                queries_seen++;
            end
            else if (int'(x) <= limit_of(max_col) && int'(y) <= limit_of(max_row))
            begin
                heights[int'(y) * MAP_SIDE_DEF + int'(x)] += d;
                adds_applied++;
            end
            else
                adds_ignored++;
        endfunction

        function void check_shade(bit [SHADE_W-1:0] got);
            bit [SHADE_W-1:0] want;
            if (expected_shades.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected shade %0d with no query outstanding", got);
            end
            else
            begin
                want = expected_shades.pop_front();
                shades_checked++;
                if (want != got)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("shade mismatch on result %0d: expected %0d, got %0d",
                                 shades_checked, want, got);
                end
            end
        endfunction

        function int pending();
            return expected_shades.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        req_valid;
    logic                        req_stall;
    logic                        cmd;
    logic [COORD_W-1:0]          col;
    logic [COORD_W-1:0]          row;
    logic signed [HEIGHT_W-1:0]  height_delta;
    logic                        rsp_valid;
    logic                        rsp_stall;
    logic [SHADE_W-1:0]          shade;

    shade_scoreboard sb;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;
    int cur_max_col = 255;
    int cur_max_row = 255;
    int focus_col = 0;
    int focus_row = 0;
    int phases_run = 0;

    heightmap_shade_engine_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .col          (col),
        .row          (row),
        .height_delta (height_delta),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .shade        (shade)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_shade(shade);
            if (cfg_valid && cfg_ready)
                sb.apply_register(cfg_index, cfg_data);
            if (req_valid && !req_stall)
                sb.note_request(cmd, col, row, height_delta);
            if ((rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)
                || (req_valid && !req_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Watchdog expired after %0d cycles without a transaction", quiet_cycles);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        rsp_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_request(input logic c, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y,
                                input logic signed [HEIGHT_W-1:0] d);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        cmd          <= c;
        col          <= x;
        row          <= y;
        height_delta <= d;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_for_quiet();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_HOLD) @(negedge clk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int lim, int focus);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return COORD_W'(focus + $urandom_range(0, 3));
        else if (sel < 80)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return COORD_W'(lim);
                2: return COORD_W'(lim + 1);
                default: return '1;
            endcase
        end
        return COORD_W'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] pick_delta();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return HEIGHT_W'($urandom);
        else if (sel < 70)
            return HEIGHT_W'(int'($urandom_range(0, 600)) - 300);
        case ($urandom_range(0, 3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0001;
            default: return 16'shFFFF;
        endcase
    endfunction

    task automatic run_phase(input logic [CFG_DATA_W-1:0] mx_data,
                             input logic [CFG_DATA_W-1:0] my_data,
                             input logic [CFG_DATA_W-1:0] lx_data,
                             input logic [CFG_DATA_W-1:0] ly_data,
                             input logic [CFG_DATA_W-1:0] lz_data,
                             input int items, input int mode);
        int made;
        logic c;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        made = 0;
        wait_for_quiet();
        program_register(REG_MAX_X, mx_data);
        program_register(REG_MAX_Y, my_data);
        program_register(REG_LIGHT_X, lx_data);
        program_register(REG_LIGHT_Y, ly_data);
        program_register(REG_LIGHT_Z, lz_data);
        cfg_valid <= 1'b0;
        cur_max_col = int'(mx_data[COORD_W-1:0]);
        cur_max_row = int'(my_data[COORD_W-1:0]);
        focus_col = (cur_max_col < 4) ? 0 : $urandom_range(0, cur_max_col - 3);
        focus_row = (cur_max_row < 4) ? 0 : $urandom_range(0, cur_max_row - 3);
        case (mode)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 75; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 75; end
            default: begin sender_idle_pct = 12; stall_pct = 12; end
        endcase
        while (made < items)
        begin
            c = 1'($urandom_range(0, 1));
            x = pick_coord(cur_max_col, focus_col);
            y = pick_coord(cur_max_row, focus_row);
            send_request(c, x, y, pick_delta());
            made++;
        end
        req_valid <= 1'b0;
        phases_run++;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] mx;
        logic [CFG_DATA_W-1:0] my;
        sb = new();
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        req_valid    <= 1'b0;
        cmd          <= CMD_ADD;
        col          <= '0;
        row          <= '0;
        height_delta <= '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: flat map, extreme heights, wrap and map corners.
        send_request(CMD_QUERY, 8'd0, 8'd0, 16'sd0);
        send_request(CMD_QUERY, 8'd255, 8'd255, 16'sd0);
        send_request(CMD_ADD, 8'd10, 8'd10, 16'sh7FFF);
        send_request(CMD_ADD, 8'd10, 8'd11, 16'sh8000);
        send_request(CMD_ADD, 8'd11, 8'd10, 16'sh7FFF);
        send_request(CMD_QUERY, 8'd10, 8'd10, 16'sd0);
        send_request(CMD_QUERY, 8'd10, 8'd11, 16'sd0);
        send_request(CMD_QUERY, 8'd11, 8'd10, 16'sd0);
        send_request(CMD_QUERY, 8'd9, 8'd10, 16'sd0);
        send_request(CMD_QUERY, 8'd10, 8'd9, 16'sd0);
        send_request(CMD_ADD, 8'd10, 8'd10, 16'sd1);
        send_request(CMD_QUERY, 8'd10, 8'd12, 16'sd0);
        send_request(CMD_ADD, 8'd0, 8'd0, 16'sh8000);
        send_request(CMD_QUERY, 8'd0, 8'd0, 16'sd0);
        send_request(CMD_QUERY, 8'd1, 8'd0, 16'sd0);
        send_request(CMD_ADD, 8'd255, 8'd255, 16'sh7FFF);
        send_request(CMD_QUERY, 8'd255, 8'd254, 16'sd0);
        send_request(CMD_QUERY, 8'd255, 8'd255, 16'sd0);
        send_request(CMD_ADD, 8'd255, 8'd0, 16'sh5555);
        send_request(CMD_ADD, 8'd0, 8'd255, 16'shAAAA);
        send_request(CMD_QUERY, 8'd254, 8'd0, 16'sd0);
        send_request(CMD_QUERY, 8'd0, 8'd254, 16'sd0);
        req_valid <= 1'b0;

        run_phase(10'd255, 10'd255, 10'd0, 10'd142, 10'd213, PHASE_ITEMS, 0);
        run_phase(10'h300, 10'h200, 10'h200, 10'h1FF, 10'h200, PHASE_ITEMS, 1);
        run_phase(10'h3FF, 10'd255, 10'h1FF, 10'h200, 10'h1FF, PHASE_ITEMS, 2);
        run_phase(10'd3, 10'd200, 10'd256, -10'sd256, -10'sd256, PHASE_ITEMS, 3);
        for (int p = 4; p < PHASE_COUNT; p++)
        begin
            mx = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 7))
                                      : CFG_DATA_W'($urandom_range(0, 255));
            my = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 7))
                                      : CFG_DATA_W'($urandom_range(0, 255));
            mx[CFG_DATA_W-1:COORD_W] = (CFG_DATA_W - COORD_W)'($urandom);
            my[CFG_DATA_W-1:COORD_W] = (CFG_DATA_W - COORD_W)'($urandom);
            run_phase(mx, my, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom), PHASE_ITEMS, p % 4);
        end

        wait_for_quiet();
        $display("Ran %0d configuration phases: %0d queries, %0d adds applied, %0d adds ignored.",
                 phases_run, sb.queries_seen, sb.adds_applied, sb.adds_ignored);
        $display("Checked %0d shades, %0d mismatches, %0d still outstanding.",
                 sb.shades_checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
